FILE: src/etc_pkg.sv
package etc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_HYST     = 3'd0;
    localparam logic [2:0] REG_BIG      = 3'd1;
    localparam logic [2:0] REG_COOL     = 3'd2;
    localparam logic [2:0] REG_FAN_OFF  = 3'd3;
    localparam logic [2:0] REG_FAN_MID  = 3'd4;
    localparam logic [2:0] REG_FAN_ON   = 3'd5;

    localparam logic [1:0] MODE_STANDBY  = 2'd0;
    localparam logic [1:0] MODE_COOLDOWN = 2'd1;
    localparam logic [1:0] MODE_PRINTING = 2'd2;

    // serial scaler: one multiplier bit, then one quotient bit per cycle
    localparam logic [3:0] MUL_STEPS  = 4'd7;
    localparam logic [3:0] LAST_STEP  = 4'd14;

    typedef struct packed {
        logic [5:0] hysteresis_margin;
        logic [6:0] big_difference;
        logic [6:0] cooldown_margin;
        logic [7:0] fan_off_level;
        logic [7:0] fan_mid_level;
        logic [7:0] fan_on_level;
    } cfg_t;

endpackage

FILE: src/etc_regs.sv
module etc_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [etc_pkg::ADDR_W-1:0]  paddr,
    input  logic [etc_pkg::DATA_W-1:0]  pwdata,
    output logic [etc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output etc_pkg::cfg_t               cfg
);

    etc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hysteresis_margin <= 6'd2;
            cfg_reg.big_difference    <= 7'd10;
            cfg_reg.cooldown_margin   <= 7'd5;
            cfg_reg.fan_off_level     <= 8'd0;
            cfg_reg.fan_mid_level     <= 8'd128;
            cfg_reg.fan_on_level      <= 8'd255;
        end else if (wr_en) begin
            case (index)
                etc_pkg::REG_HYST:    cfg_reg.hysteresis_margin <= pwdata[5:0];
                etc_pkg::REG_BIG:     cfg_reg.big_difference    <= pwdata[6:0];
                etc_pkg::REG_COOL:    cfg_reg.cooldown_margin   <= pwdata[6:0];
                etc_pkg::REG_FAN_OFF: cfg_reg.fan_off_level     <= pwdata[7:0];
                etc_pkg::REG_FAN_MID: cfg_reg.fan_mid_level     <= pwdata[7:0];
                etc_pkg::REG_FAN_ON:  cfg_reg.fan_on_level      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            etc_pkg::REG_HYST:    prdata = {26'd0, cfg_reg.hysteresis_margin};
            etc_pkg::REG_BIG:     prdata = {25'd0, cfg_reg.big_difference};
            etc_pkg::REG_COOL:    prdata = {25'd0, cfg_reg.cooldown_margin};
            etc_pkg::REG_FAN_OFF: prdata = {24'd0, cfg_reg.fan_off_level};
            etc_pkg::REG_FAN_MID: prdata = {24'd0, cfg_reg.fan_mid_level};
            etc_pkg::REG_FAN_ON:  prdata = {24'd0, cfg_reg.fan_on_level};
            default:              prdata = '0;
        endcase
    end

endmodule

FILE: src/etc_scaler.sv
module etc_scaler (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [6:0] mult_a,
    input  logic [7:0] mult_b,
    input  logic [6:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [14:0] acc_reg, acc_next;
    logic [14:0] mcand_reg, mcand_next;
    logic [6:0]  mplier_reg, mplier_next;
    logic [6:0]  span_reg, span_next;
    logic [7:0]  shifted;
    logic [7:0]  trial;
    logic        ge;

    assign shifted  = {acc_reg[14:8], acc_reg[7]};
    assign ge       = shifted >= {1'b0, span_reg};
    assign trial    = shifted - {1'b0, span_reg};
    assign done     = done_reg;
    assign quotient = acc_reg[7:0];

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        span_next   = span_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = {7'd0, mult_b};
            mplier_next = mult_a;
            span_next   = divisor;
        end else if (busy_reg) begin
            if (cnt_reg < etc_pkg::MUL_STEPS) begin
                // shift-add, one multiplier bit per cycle
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[13:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[6:1]};
            end else begin
                // restoring division in place, quotient shifts in at the bottom
                acc_next = {(ge ? trial[6:0] : shifted[6:0]), acc_reg[6:0], ge};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == etc_pkg::LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        span_reg   <= span_next;
    end

endmodule

FILE: src/enclosure_thermostat_controller_top.sv
// enclosure thermostat controller
// input channel s_*: one control tick per item (mode, temperatures, door, lights),
// valid/ready handshake. result channel m_*: one result item per tick with
// heater, fan, supply and servo commands plus their update flags.
// configuration: APB-style port, six registers at byte addresses 0x00..0x14;
// the user must write them only while no item is in flight, since the block
// does not enforce it; pready is always high. an item is captured, evaluated
// and its result loaded into the output register; a tick that needs linear fan
// scaling also passes through the serial scaler, which does a 7-step shift-add
// multiply followed by an 8-step restoring divide. one item is worked on at a
// time, so a new item is taken once the previous result has been loaded into
// the output register. the output register holds a result while the receiver
// stalls; the next item's result waits inside until that register is free.
// reset: registers return to their defaults (hysteresis 2, big difference 10,
// cooldown margin 5, fan off 0, mid 128, on 255), the heating flag and the
// hysteresis latch clear and the previous mode becomes standby.
module enclosure_thermostat_controller_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operating_mode,
    input  logic signed [8:0]           s_inside_temp,
    input  logic signed [8:0]           s_outside_temp,
    input  logic [7:0]                  s_target_temp,
    input  logic                        s_door_open,
    input  logic                        s_lights_need_power,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_heater_on,
    output logic [7:0]                  m_fan_level,
    output logic                        m_drive_update,
    output logic                        m_supply_on,
    output logic                        m_supply_update,
    output logic                        m_servos_home,
    output logic                        m_cooldown_finished,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [etc_pkg::ADDR_W-1:0]  paddr,
    input  logic [etc_pkg::DATA_W-1:0]  pwdata,
    output logic [etc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    etc_pkg::cfg_t cfg;

    logic [1:0] state_reg, state_next;

    // captured item
    logic [1:0]        mode_reg;
    logic signed [8:0] inside_reg;
    logic signed [8:0] outside_reg;
    logic [7:0]        target_reg;
    logic              door_reg;
    logic              lights_reg;

    // controller state
    logic       heating_reg, heating_next;
    logic       latch_reg, latch_next;
    logic [1:0] prev_mode_reg;

    // pending result
    logic       res_heater_reg;
    logic [7:0] res_fan_reg;
    logic       res_drive_reg;
    logic       res_supply_reg;
    logic       res_supupd_reg;
    logic       res_servos_reg;
    logic       res_fin_reg;

    // output register
    logic       m_valid_reg;
    logic       m_heater_reg;
    logic [7:0] m_fan_reg;
    logic       m_drive_reg;
    logic       m_supply_reg;
    logic       m_supupd_reg;
    logic       m_servos_reg;
    logic       m_fin_reg;

    // decision
    logic       d_heater, d_drive, d_supply, d_supupd, d_servos, d_fin, d_scale;
    logic [7:0] d_fan;
    logic       heat_eff;

    logic signed [10:0] in_s, out_s, tg_s, h_s, b_s, c_s, diff_s;
    logic               gt, cool_run, heat_low, far_hot, over_h, over_b, far_cold;

    logic signed [8:0] delta;
    logic              delta_neg;
    logic [7:0]        delta_mag;
    logic              scale_start;
    logic              scale_done;
    logic [7:0]        scale_q;
    logic [7:0]        scaled_fan;
    logic              out_free;

    etc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_s   = {{2{inside_reg[8]}}, inside_reg};
    assign out_s  = {{2{outside_reg[8]}}, outside_reg};
    assign tg_s   = {3'd0, target_reg};
    assign h_s    = {5'd0, cfg.hysteresis_margin};
    assign b_s    = {4'd0, cfg.big_difference};
    assign c_s    = {4'd0, cfg.cooldown_margin};
    assign diff_s = in_s - tg_s;

    assign gt       = in_s > tg_s;
    assign cool_run = (in_s - c_s) > out_s;
    assign heat_low = (in_s + h_s) < tg_s;
    assign far_hot  = (in_s - b_s) > tg_s;
    assign over_h   = in_s > (tg_s + h_s);
    assign over_b   = in_s > (tg_s + b_s);
    assign far_cold = (in_s + b_s) < tg_s;

    assign delta     = $signed({1'b0, cfg.fan_on_level}) - $signed({1'b0, cfg.fan_off_level});
    assign delta_neg = delta[8];
    assign delta_mag = delta_neg ? 8'(-delta) : delta[7:0];

    // entering printing re-seeds the heating flag and clears the latch
    assign heat_eff = (prev_mode_reg != etc_pkg::MODE_PRINTING) ? !gt : heating_reg;

    always_comb begin
        d_heater     = 1'b0;
        d_fan        = '0;
        d_drive      = 1'b0;
        d_supply     = 1'b0;
        d_supupd     = 1'b0;
        d_servos     = 1'b0;
        d_fin        = 1'b0;
        d_scale      = 1'b0;
        heating_next = heating_reg;
        latch_next   = latch_reg;
        case (mode_reg)
            etc_pkg::MODE_COOLDOWN: begin
                if (cool_run) begin
                    d_supply = !door_reg || lights_reg;
                    d_supupd = 1'b1;
                    d_drive  = 1'b1;
                    d_fan    = cfg.fan_on_level;
                end else begin
                    d_fin = 1'b1;
                end
            end
            etc_pkg::MODE_PRINTING: begin
                d_supply     = 1'b1;
                d_supupd     = 1'b1;
                heating_next = heat_eff;
                latch_next   = (prev_mode_reg != etc_pkg::MODE_PRINTING) ? 1'b0 : latch_reg;
                if (heat_eff) begin
                    if (heat_low) begin
                        d_drive  = 1'b1;
                        d_heater = 1'b1;
                        d_fan    = cfg.fan_off_level;
                    end else if (far_hot) begin
                        heating_next = 1'b0;
                        d_drive      = 1'b1;
                        d_fan        = cfg.fan_mid_level;
                    end else if (gt) begin
                        d_drive = 1'b1;
                        d_fan   = cfg.fan_off_level;
                    end
                end else begin
                    d_drive = 1'b1;
                    if (gt) begin
                        if (over_h) begin
                            latch_next = 1'b1;
                        end
                        if (!latch_next) begin
                            d_fan = cfg.fan_off_level;
                        end else if (over_b) begin
                            d_fan = cfg.fan_on_level;
                        end else begin
                            d_scale = 1'b1;
                        end
                    end else if (far_cold) begin
                        heating_next = 1'b1;
                        latch_next   = 1'b0;
                        d_heater     = 1'b1;
                        d_fan        = cfg.fan_off_level;
                    end else begin
                        latch_next = 1'b0;
                        d_fan      = cfg.fan_off_level;
                    end
                end
            end
            default: begin
                // standby, and the unused mode code
                d_drive  = 1'b1;
                d_fan    = cfg.fan_off_level;
                d_servos = 1'b1;
                d_supply = lights_reg;
                d_supupd = 1'b1;
            end
        endcase
    end

    assign scale_start = (state_reg == ST_EVAL) && d_scale;

    etc_scaler u_scaler (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scale_start),
        .mult_a   (diff_s[6:0]),
        .mult_b   (delta_mag),
        .divisor  (cfg.big_difference),
        .done     (scale_done),
        .quotient (scale_q)
    );

    // truncation toward zero: apply the sign to the magnitude quotient
    assign scaled_fan = (cfg.big_difference == 7'd0) ? cfg.fan_off_level :
                        cfg.fan_off_level + (delta_neg ? 8'(-scale_q) : scale_q);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_EVAL;
            ST_EVAL:  state_next = d_scale ? ST_SCALE : ST_OUT;
            ST_SCALE: if (scale_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            heating_reg   <= 1'b0;
            latch_reg     <= 1'b0;
            prev_mode_reg <= etc_pkg::MODE_STANDBY;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EVAL) begin
                heating_reg   <= heating_next;
                latch_reg     <= latch_next;
                prev_mode_reg <= mode_reg;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg    <= s_operating_mode;
            inside_reg  <= s_inside_temp;
            outside_reg <= s_outside_temp;
            target_reg  <= s_target_temp;
            door_reg    <= s_door_open;
            lights_reg  <= s_lights_need_power;
        end
        if (state_reg == ST_EVAL) begin
            res_heater_reg <= d_heater;
            res_fan_reg    <= d_fan;
            res_drive_reg  <= d_drive;
            res_supply_reg <= d_supply;
            res_supupd_reg <= d_supupd;
            res_servos_reg <= d_servos;
            res_fin_reg    <= d_fin;
        end else if (state_reg == ST_SCALE && scale_done) begin
            res_fan_reg <= scaled_fan;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_heater_reg <= res_heater_reg;
            m_fan_reg    <= res_fan_reg;
            m_drive_reg  <= res_drive_reg;
            m_supply_reg <= res_supply_reg;
            m_supupd_reg <= res_supupd_reg;
            m_servos_reg <= res_servos_reg;
            m_fin_reg    <= res_fin_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_heater_on         = m_heater_reg;
    assign m_fan_level         = m_fan_reg;
    assign m_drive_update      = m_drive_reg;
    assign m_supply_on         = m_supply_reg;
    assign m_supply_update     = m_supupd_reg;
    assign m_servos_home       = m_servos_reg;
    assign m_cooldown_finished = m_fin_reg;

endmodule
